[rtl/kwqe_pkg.sv]
// ---------------------------------------------------------------------------
// Keyed wait queue engine package
// Widths, stream layout, command/status codes and sequencer states.
// ---------------------------------------------------------------------------
package kwqe_pkg;

    // Waiter slots and hashing
    localparam int THREADS      = 64;
    localparam int SLOT_W       = $clog2(THREADS);
    localparam int CNT_W        = $clog2(THREADS + 1);
    localparam int BUCKET_COUNT = 251;
    localparam int BKT_W        = $clog2(BUCKET_COUNT);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 48;
    localparam int TID_W   = 6;
    localparam int VAL_W   = 64;
    localparam int START_W = 62;
    localparam int TIME_W  = 63;
    localparam int INTV_W  = 32;
    localparam int ORDER_W = 32;
    localparam int STAT_W  = 3;

    // Remainder is formed two key bits per step
    localparam int MOD_STEPS = KEY_W / 2;

    localparam logic [INTV_W-1:0] FAIR_RESET = INTV_W'(1000 * 1000);

    // Input tdata layout, lowest bit first
    localparam int KEY_LO   = 0;
    localparam int TID_LO   = KEY_LO + KEY_W;
    localparam int CUR_LO   = TID_LO + TID_W;
    localparam int EXP_LO   = CUR_LO + VAL_W;
    localparam int START_LO = EXP_LO + VAL_W;
    localparam int NOW_LO   = START_LO + START_W;
    localparam int S_BITS   = NOW_LO + TIME_W;
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;

    // Output tdata layout: woken_thread, bucket_waiting, be_fair
    localparam int M_TDATA_W = ((TID_W + 2 + 7) / 8) * 8;
    localparam int M_TUSER_W = STAT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PARK,
        CMD_UNPARK_ONE,
        CMD_UNPARK_ALL,
        CMD_CANCEL
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_PARKED,
        STAT_VALUE_CHANGED,
        STAT_WOKEN,
        STAT_NO_WAITER,
        STAT_CANCELLED,
        STAT_NOT_QUEUED,
        STAT_REFUSED
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WRITE,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } state_t;

    // One waiter slot as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [ORDER_W-1:0] order;
        logic [BKT_W-1:0]   bucket;
        logic [KEY_W-1:0]   key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/kwqe_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module kwqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/keyed_wait_queue_engine_top.sv]
// ---------------------------------------------------------------------------
// Keyed wait queue engine
// Address-keyed wait queues with one waiter slot per thread.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Moves
//  ---------+-----------+----------------------------------------------------
//  s_       | in        | command: tuser = cmd, tdata = key..now_time
//  m_       | out       | result: tuser = status, tdata = thread/flags, tlast
//  cfg_     | in        | fair_interval write
//
//  Park: accept, key-mod-bucket remainder (two key bits per step in one
//  shared compare/subtract unit), write, emit. Unpark: accept, remainder,
//  then per result a scan (one slot memory read per cycle over all 64
//  slots), decide and emit; unpark-all repeats scan, decide and emit for
//  each woken thread. Cancel and refusals go from accept straight to emit.
//  s_tready is high only while idle. A result waits in the output register
//  while the next command is taken. Synchronous active-low reset clears
//  all slot valid bits and the arrival counter; no memory clearing pass.
// ---------------------------------------------------------------------------
module keyed_wait_queue_engine_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command transaction
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_address, thread_id, current_value, expected_value, park_time,
    // now_time
    input  logic [kwqe_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [kwqe_pkg::S_TUSER_W-1:0] s_tuser,
    // result transaction
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // woken_thread, bucket_waiting, be_fair
    output logic [kwqe_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [kwqe_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kwqe_pkg::INTV_W-1:0]    cfg_data
);

    import kwqe_pkg::*;

    localparam logic [BKT_W+1:0] BKT_1X = (BKT_W + 2)'(BUCKET_COUNT);
    localparam logic [BKT_W+1:0] BKT_2X = (BKT_W + 2)'(2 * BUCKET_COUNT);
    localparam logic [BKT_W+1:0] BKT_3X = (BKT_W + 2)'(3 * BUCKET_COUNT);

    // Input field views
    cmd_t               s_cmd;
    logic [KEY_W-1:0]   s_key;
    logic [TID_W-1:0]   s_tid;
    logic [VAL_W-1:0]   s_cur;
    logic [VAL_W-1:0]   s_exp;
    logic [START_W-1:0] s_start;
    logic [TIME_W-1:0]  s_now;
    logic [SLOT_W-1:0]  s_slot;
    logic               s_tid_ok;

    assign s_cmd    = cmd_t'(s_tuser[CMD_W-1:0]);
    assign s_key    = s_tdata[KEY_LO +: KEY_W];
    assign s_tid    = s_tdata[TID_LO +: TID_W];
    assign s_cur    = s_tdata[CUR_LO +: VAL_W];
    assign s_exp    = s_tdata[EXP_LO +: VAL_W];
    assign s_start  = s_tdata[START_LO +: START_W];
    assign s_now    = s_tdata[NOW_LO +: TIME_W];
    assign s_slot   = SLOT_W'(s_tid);
    assign s_tid_ok = int'(s_tid) < THREADS;

    // Registers
    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    mod_sh_reg, mod_sh_next;
    logic [SLOT_W-1:0]   tid_reg, tid_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   dl_reg, dl_next;
    logic [BKT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [THREADS-1:0]  valid_reg, valid_next;
    logic [ORDER_W-1:0]  arrival_reg, arrival_next;
    logic [INTV_W-1:0]   fair_reg, fair_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   best_idx_reg, best_idx_next;
    logic [ORDER_W-1:0]  best_age_reg, best_age_next;
    logic [TIME_W-1:0]   best_dl_reg, best_dl_next;
    logic [CNT_W-1:0]    bcnt_reg, bcnt_next;
    logic [CNT_W-1:0]    kcnt_reg, kcnt_next;
    status_t             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_thread_reg, res_thread_next;
    logic                res_more_reg, res_more_next;
    logic                res_fair_reg, res_fair_next;
    logic                res_last_reg, res_last_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [SLOT_W-1:0]   m_thread_reg, m_thread_next;
    logic                m_more_reg, m_more_next;
    logic                m_fair_reg, m_fair_next;
    logic                m_last_reg, m_last_next;

    // Slot memory
    logic                ram_we;
    entry_t              ram_wentry;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;

    assign ram_wentry = '{deadline: dl_reg, order: arrival_reg,
                          bucket: rem_reg, key: key_reg};
    assign rd_entry   = entry_t'(ram_rdata);

    kwqe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (THREADS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tid_reg),
        .wdata (ram_wentry),
        .raddr (cnt_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // Shared remainder step: (4 * rem + digit) mod BUCKET_COUNT
    logic [BKT_W+1:0] mod_acc;
    logic [BKT_W+1:0] mod_red;

    assign mod_acc = {rem_reg, 2'b00} + (BKT_W + 2)'(mod_sh_reg[KEY_W-1 -: 2]);

    always_comb begin
        if (mod_acc >= BKT_3X) begin
            mod_red = mod_acc - BKT_3X;
        end else if (mod_acc >= BKT_2X) begin
            mod_red = mod_acc - BKT_2X;
        end else if (mod_acc >= BKT_1X) begin
            mod_red = mod_acc - BKT_1X;
        end else begin
            mod_red = mod_acc;
        end
    end

    // Scan compare on the slot read last cycle
    logic [SLOT_W-1:0]  ev_idx;
    logic               ev_valid;
    logic [ORDER_W-1:0] ev_age;
    logic               ev_key_hit;
    logic               ev_bkt_hit;

    assign ev_idx     = SLOT_W'(cnt_reg - CNT_W'(1));
    assign ev_valid   = valid_reg[ev_idx];
    assign ev_age     = arrival_reg - rd_entry.order;
    assign ev_key_hit = ev_valid && (rd_entry.key == key_reg);
    assign ev_bkt_hit = ev_valid && (rd_entry.bucket == rem_reg);

    // Handshakes
    logic out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        mod_sh_next     = mod_sh_reg;
        tid_next        = tid_reg;
        now_next        = now_reg;
        dl_next         = dl_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        arrival_next    = arrival_reg;
        fair_next       = fair_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_dl_next    = best_dl_reg;
        bcnt_next       = bcnt_reg;
        kcnt_next       = kcnt_reg;
        res_status_next = res_status_reg;
        res_thread_next = res_thread_reg;
        res_more_next   = res_more_reg;
        res_fair_next   = res_fair_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_thread_next   = m_thread_reg;
        m_more_next     = m_more_reg;
        m_fair_next     = m_fair_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;

        // Take a register write
        if (cfg_valid) begin
            fair_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = s_cmd;
                    key_next        = s_key;
                    mod_sh_next     = s_key;
                    tid_next        = s_slot;
                    now_next        = s_now;
                    dl_next         = TIME_W'(s_start) + TIME_W'(fair_reg);
                    rem_next        = '0;
                    cnt_next        = '0;
                    res_thread_next = '0;
                    res_more_next   = 1'b0;
                    res_fair_next   = 1'b0;
                    res_last_next   = 1'b1;
                    case (s_cmd)
                        CMD_PARK: begin
                            if (!s_tid_ok || valid_reg[s_slot]) begin
                                res_status_next = STAT_REFUSED;
                                state_next      = S_EMIT;
                            end else if (s_cur != s_exp) begin
                                res_status_next = STAT_VALUE_CHANGED;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_MOD;
                            end
                        end
                        CMD_CANCEL: begin
                            if (s_tid_ok && valid_reg[s_slot]) begin
                                valid_next[s_slot] = 1'b0;
                                res_status_next    = STAT_CANCELLED;
                            end else begin
                                res_status_next = STAT_NOT_QUEUED;
                            end
                            state_next = S_EMIT;
                        end
                        default: begin
                            state_next = S_MOD;
                        end
                    endcase
                end
            end

            // Reduce the key to its bucket, two bits a cycle
            S_MOD: begin
                rem_next    = BKT_W'(mod_red);
                mod_sh_next = {mod_sh_reg[KEY_W-3:0], 2'b00};
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MOD_STEPS - 1)) begin
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    bcnt_next     = '0;
                    kcnt_next     = '0;
                    if (cmd_reg == CMD_PARK) begin
                        state_next = S_WRITE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // Store the new waiter
            S_WRITE: begin
                ram_we          = 1'b1;
                valid_next[tid_reg] = 1'b1;
                arrival_next    = arrival_reg + ORDER_W'(1);
                res_status_next = STAT_PARKED;
                state_next      = S_EMIT;
            end

            // Walk all slots: oldest on key, key count, bucket count
            S_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0) begin
                    if (ev_bkt_hit) begin
                        bcnt_next = bcnt_reg + CNT_W'(1);
                    end
                    if (ev_key_hit) begin
                        kcnt_next = kcnt_reg + CNT_W'(1);
                        if (!found_reg || ev_age > best_age_reg) begin
                            found_next    = 1'b1;
                            best_idx_next = ev_idx;
                            best_age_next = ev_age;
                            best_dl_next  = rd_entry.deadline;
                        end
                    end
                end
                if (cnt_reg == CNT_W'(THREADS)) begin
                    state_next = S_DECIDE;
                end
            end

            // Form the result and drop the woken waiter
            S_DECIDE: begin
                res_fair_next = 1'b0;
                if (!found_reg) begin
                    res_status_next = STAT_NO_WAITER;
                    res_thread_next = '0;
                    res_more_next   = (bcnt_reg != '0);
                    res_last_next   = 1'b1;
                end else begin
                    valid_next[best_idx_reg] = 1'b0;
                    res_status_next = STAT_WOKEN;
                    res_thread_next = best_idx_reg;
                    res_more_next   = (bcnt_reg >= CNT_W'(2));
                    if (cmd_reg == CMD_UNPARK_ONE) begin
                        res_fair_next = (now_reg >= best_dl_reg);
                        res_last_next = 1'b1;
                    end else begin
                        res_last_next = (kcnt_reg == CNT_W'(1));
                    end
                end
                state_next = S_EMIT;
            end

            // Hand the result to the output register
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_thread_next = res_thread_reg;
                    m_more_next   = res_more_reg;
                    m_fair_next   = res_fair_reg;
                    m_last_next   = res_last_reg;
                    if (cmd_reg == CMD_UNPARK_ALL && !res_last_reg) begin
                        cnt_next   = '0;
                        found_next = 1'b0;
                        bcnt_next  = '0;
                        kcnt_next  = '0;
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            arrival_reg <= '0;
            fair_reg    <= FAIR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            arrival_reg <= arrival_next;
            fair_reg    <= fair_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        mod_sh_reg     <= mod_sh_next;
        tid_reg        <= tid_next;
        now_reg        <= now_next;
        dl_reg         <= dl_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_dl_reg    <= best_dl_next;
        bcnt_reg       <= bcnt_next;
        kcnt_reg       <= kcnt_next;
        res_status_reg <= res_status_next;
        res_thread_reg <= res_thread_next;
        res_more_reg   <= res_more_next;
        res_fair_reg   <= res_fair_next;
        res_last_reg   <= res_last_next;
        m_status_reg   <= m_status_next;
        m_thread_reg   <= m_thread_next;
        m_more_reg     <= m_more_next;
        m_fair_reg     <= m_fair_next;
        m_last_reg     <= m_last_next;
    end

    // Result ports
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'({m_fair_reg, m_more_reg, TID_W'(m_thread_reg)});
    assign m_tlast  = m_last_reg;

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Keyed wait queue engine testbench
// Drives park, unpark-one, unpark-all and cancel commands into the engine
// and predicts every result from a behavioral copy of the waiter slots.
// Results are checked field by field, in order. The fairness interval is
// changed between phases, both channels idle at random, and the result side
// is held off once for a long stretch so that the engine stalls its input.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kwqe_pkg::*;

    // One expected result transaction
    typedef struct packed {
        status_t          status;
        logic [TID_W-1:0] thread;
        logic             more;
        logic             fair;
        logic             last;
    } wake_result_t;

    // Waiter slots, arrival order and the results they must produce
    class park_queue_predictor;
        bit                 slot_used[THREADS];
        logic [KEY_W-1:0]   slot_addr[THREADS];
        logic [TIME_W-1:0]  slot_due[THREADS];
        bit [ORDER_W-1:0]   slot_seq[THREADS];
        bit [ORDER_W-1:0]   arrivals;
        bit [INTV_W-1:0]    interval;
        wake_result_t       pending_results[$];
        int                 errors;
        int                 commands;
        int                 results;
        int                 status_seen[7];

        function new();
            interval = FAIR_RESET;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Any live waiter whose key lands in the same hash bucket
        function bit bucket_busy(logic [KEY_W-1:0] k);
            for (int i = 0; i < THREADS; i++)
                if (slot_used[i] && (slot_addr[i] % BUCKET_COUNT) == (k % BUCKET_COUNT))
                    return 1'b1;
            return 1'b0;
        endfunction

        // Oldest waiter on a key; ties go to the lowest slot
        function int oldest_waiter(logic [KEY_W-1:0] k);
            int               best;
            bit [ORDER_W-1:0] best_age;
            bit [ORDER_W-1:0] age;
            best = -1;
            best_age = '0;
            for (int i = 0; i < THREADS; i++) begin
                if (slot_used[i] && slot_addr[i] == k) begin
                    age = arrivals - slot_seq[i];
                    if (best < 0 || age > best_age) begin
                        best = i;
                        best_age = age;
                    end
                end
            end
            return best;
        endfunction

        // Random queued thread, or -1 when nothing waits
        function int any_waiter();
            int start;
            start = $urandom_range(0, THREADS - 1);
            for (int i = 0; i < THREADS; i++)
                if (slot_used[(start + i) % THREADS])
                    return (start + i) % THREADS;
            return -1;
        endfunction

        function void add(status_t s, int th, bit m, bit f, bit l);
            wake_result_t r;
            r.status = s;
            r.thread = TID_W'(th);
            r.more = m;
            r.fair = f;
            r.last = l;
            pending_results.push_back(r);
        endfunction

        // Apply one accepted command and queue its results
        function void note_command(cmd_t c, logic [KEY_W-1:0] k, logic [TID_W-1:0] t,
                                   logic [VAL_W-1:0] cur, logic [VAL_W-1:0] exv,
                                   logic [START_W-1:0] st, logic [TIME_W-1:0] nw);
            int w;
            int nx;
            commands++;
            case (c)
                CMD_PARK: begin
                    if (slot_used[t]) begin
                        add(STAT_REFUSED, 0, 0, 0, 1);
                    end else if (cur != exv) begin
                        add(STAT_VALUE_CHANGED, 0, 0, 0, 1);
                    end else begin
                        slot_used[t] = 1'b1;
                        slot_addr[t] = k;
                        slot_due[t] = TIME_W'(st) + TIME_W'(interval);
                        slot_seq[t] = arrivals;
                        arrivals++;
                        add(STAT_PARKED, 0, 0, 0, 1);
                    end
                end
                CMD_UNPARK_ONE: begin
                    w = oldest_waiter(k);
                    if (w < 0) begin
                        add(STAT_NO_WAITER, 0, bucket_busy(k), 0, 1);
                    end else begin
                        slot_used[w] = 1'b0;
                        add(STAT_WOKEN, w, bucket_busy(k), nw >= slot_due[w], 1);
                    end
                end
                CMD_UNPARK_ALL: begin
                    w = oldest_waiter(k);
                    if (w < 0)
                        add(STAT_NO_WAITER, 0, bucket_busy(k), 0, 1);
                    while (w >= 0) begin
                        slot_used[w] = 1'b0;
                        nx = oldest_waiter(k);
                        add(STAT_WOKEN, w, bucket_busy(k), 0, nx < 0);
                        w = nx;
                    end
                end
                default: begin
                    if (slot_used[t]) begin
                        slot_used[t] = 1'b0;
                        add(STAT_CANCELLED, 0, 0, 0, 1);
                    end else begin
                        add(STAT_NOT_QUEUED, 0, 0, 0, 1);
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        // Compare one result transaction with the oldest expectation
        task check_result(logic [STAT_W-1:0] s, logic [TID_W-1:0] th, logic m, logic f,
                          logic l);
            wake_result_t e;
            results++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d", s));
            end else begin
                e = pending_results.pop_front();
                if (s <= STAT_REFUSED)
                    status_seen[s]++;
                if (s !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d", s, e.status));
                if (th !== e.thread)
                    report_mismatch($sformatf("woken thread %0d, want %0d", th, e.thread));
                if (m !== e.more)
                    report_mismatch($sformatf("bucket flag %b, want %b", m, e.more));
                if (f !== e.fair)
                    report_mismatch($sformatf("be_fair %b, want %b", f, e.fair));
                if (l !== e.last)
                    report_mismatch($sformatf("tlast %b, want %b", l, e.last));
            end
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = CMD_PARK;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [INTV_W-1:0]    cfg_data = '0;

    park_queue_predictor  model = new();
    bit                   idle_on = 1'b1;
    bit                   hold_req = 1'b0;
    bit                   hold_rx = 1'b0;
    int                   stall_left = 0;
    int                   settings_used = 1;
    logic [START_W-1:0]   base_time = START_W'(1000);

    // Keys in colliding pairs so that bucket occupancy differs from key occupancy
    logic [KEY_W-1:0] key_pool[8] = '{
        48'h0, 48'd251, 48'h5, 48'd251005,
        48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FF04, 48'h1234_5678_9ABC, 48'h1234_5678_9BB7
    };

    keyed_wait_queue_engine_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: check each transaction, then pick the next ready level
    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                model.check_result(m_tuser, m_tdata[TID_W-1:0], m_tdata[TID_W],
                                   m_tdata[TID_W+1], m_tlast);
            if (hold_rx) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on)
                    stall_left = pick_gap();
            end
        end
    end

    // Long hold-off of the result side, counted here
    initial begin
        forever begin
            wait (hold_req);
            hold_req = 1'b0;
            hold_rx = 1'b1;
            repeat (400) @(posedge aclk);
            hold_rx = 1'b0;
        end
    end

    // Offer one command and hold it until the engine takes it
    task automatic send_command(cmd_t c, logic [KEY_W-1:0] k, int t, logic [VAL_W-1:0] cur,
                                logic [VAL_W-1:0] exv, logic [START_W-1:0] st,
                                logic [TIME_W-1:0] nw);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[KEY_LO +: KEY_W] = k;
        word[TID_LO +: TID_W] = TID_W'(t);
        word[CUR_LO +: VAL_W] = cur;
        word[EXP_LO +: VAL_W] = exv;
        word[START_LO +: START_W] = st;
        word[NOW_LO +: TIME_W] = nw;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= c;
        do @(posedge aclk); while (!s_tready);
        model.note_command(c, k, TID_W'(t), cur, exv, st, nw);
    endtask

    // Stop offering and let every expected result come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (model.pending() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_interval(logic [INTV_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.interval = v;
        settings_used++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return KEY_W'({$urandom, $urandom});
        return key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [START_W-1:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 14)
            return '1;
        if (r < 22)
            return START_W'({$urandom, $urandom});
        return base_time + START_W'($urandom_range(0, 5000));
    endfunction

    function automatic logic [TIME_W-1:0] pick_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '1;
        if (r < 20)
            return TIME_W'({$urandom, $urandom});
        if (r < 25)
            return '0;
        return TIME_W'(base_time) + TIME_W'($urandom_range(0, 2000000));
    endfunction

    // A time right around a deadline, to hit both sides of the fairness compare
    function automatic logic [TIME_W-1:0] near_due(logic [TIME_W-1:0] due);
        int delta;
        delta = $urandom_range(0, 6) - 3;
        if (delta < 0 && due < TIME_W'(3))
            return due;
        return due + TIME_W'(delta);
    endfunction

    // One random command, steered toward live waiters much of the time
    task automatic random_command();
        int                 r;
        int                 t;
        int                 w;
        cmd_t               c;
        logic [KEY_W-1:0]   k;
        logic [VAL_W-1:0]   cur;
        logic [VAL_W-1:0]   exv;
        logic [TIME_W-1:0]  nw;
        r = $urandom_range(0, 99);
        c = r < 45 ? CMD_PARK : r < 70 ? CMD_UNPARK_ONE : r < 80 ? CMD_UNPARK_ALL : CMD_CANCEL;
        k = pick_key();
        t = $urandom_range(0, THREADS - 1);
        cur = {$urandom, $urandom};
        exv = ($urandom_range(0, 99) < 85) ? cur : {$urandom, $urandom};
        nw = pick_now();
        base_time += START_W'($urandom_range(0, 2000));
        w = model.any_waiter();
        if (c == CMD_CANCEL && w >= 0 && $urandom_range(0, 9) < 7)
            t = w;
        if ((c == CMD_UNPARK_ONE || c == CMD_UNPARK_ALL) && w >= 0 && $urandom_range(0, 1))
            k = model.slot_addr[w];
        if (c == CMD_UNPARK_ONE) begin
            w = model.oldest_waiter(k);
            if (w >= 0 && $urandom_range(0, 1))
                nw = near_due(model.slot_due[w]);
        end
        send_command(c, k, t, cur, exv, pick_start(), nw);
    endtask

    // Several parks on one key, then wake them all
    task automatic park_then_wake_all();
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        int               n;
        k = pick_key();
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++) begin
            v = {$urandom, $urandom};
            send_command(CMD_PARK, k, $urandom_range(0, THREADS - 1), v, v, pick_start(),
                         pick_now());
        end
        send_command(CMD_UNPARK_ALL, k, $urandom_range(0, THREADS - 1), {$urandom, $urandom},
                     {$urandom, $urandom}, pick_start(), pick_now());
    endtask

    // Run about count commands; optionally hold off the result side once
    task automatic random_phase(int count, bit with_hold);
        int done;
        int first;
        int step;
        bit held;
        first = model.commands;
        done = 0;
        step = 0;
        held = 1'b0;
        while (done < count) begin
            if (step % 16 == 0)
                idle_on = $urandom_range(0, 3) != 0;
            if (with_hold && !held && done >= 10) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                park_then_wake_all();
            else
                random_command();
            step++;
            done = model.commands - first;
        end
        wait_idle();
    endtask

    // Directed opening: codes, extremes and corner cases at the reset interval
    task automatic directed_part();
        logic [VAL_W-1:0] ones;
        ones = '1;
        send_command(CMD_UNPARK_ONE, 48'h0, 0, 0, 0, 0, 0);
        send_command(CMD_CANCEL, 48'h0, 5, 0, 0, 0, 0);
        send_command(CMD_PARK, 48'h0, 0, 0, 0, 0, 0);
        send_command(CMD_PARK, 48'h0, 0, 0, 0, 0, 0);
        send_command(CMD_PARK, 48'h0, 1, 0, 64'h1, 0, 0);
        send_command(CMD_PARK, 48'hFFFF_FFFF_FFFF, 63, ones, ones, '1, '1);
        send_command(CMD_PARK, 48'd251, 1, 64'h55, 64'h55, 10, 0);
        send_command(CMD_UNPARK_ONE, 48'h0, 9, 0, 0, 0, 999999);
        send_command(CMD_UNPARK_ONE, 48'h0, 9, 0, 0, 0, '1);
        send_command(CMD_PARK, 48'hFFFF_FFFF_FF04, 2, 7, 7, 0, 0);
        send_command(CMD_PARK, 48'hFFFF_FFFF_FFFF, 32, 1, 1, 100, 0);
        send_command(CMD_PARK, 48'hFFFF_FFFF_FFFF, 62, 2, 2, 200, 0);
        send_command(CMD_UNPARK_ONE, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, '1);
        send_command(CMD_CANCEL, 48'h0, 32, 0, 0, 0, 0);
        send_command(CMD_CANCEL, 48'h0, 32, 0, 0, 0, 0);
        send_command(CMD_UNPARK_ALL, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, '1);
        send_command(CMD_PARK, 48'h5, 16, 3, 3, 50, 0);
        send_command(CMD_PARK, 48'h5, 8, 4, 4, 60, 0);
        send_command(CMD_PARK, 48'h5, 4, 5, 5, 70, 0);
        send_command(CMD_PARK, 48'd251005, 40, 6, 6, 80, 0);
        send_command(CMD_UNPARK_ALL, 48'h5, 0, 0, 0, 0, '1);
        send_command(CMD_UNPARK_ALL, 48'h5, 0, 0, 0, 0, 0);
        send_command(CMD_UNPARK_ALL, 48'd251005, 0, 0, 0, 0, 0);
        // now equal to the deadline counts as fair
        send_command(CMD_PARK, 48'h123, 7, 9, 9, 1000, 0);
        send_command(CMD_UNPARK_ONE, 48'h123, 0, 0, 0, 0, 1001000);
        wait_idle();
    endtask

    // Main sequence
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_part();
        write_interval('0);
        random_phase(31, 1'b0);
        write_interval('1);
        random_phase(31, 1'b1);
        write_interval({$urandom});
        random_phase(31, 1'b0);
        write_interval(32'd1000);
        random_phase(31, 1'b0);
        repeat (100) @(posedge aclk);
        $display("Covered %0d commands and %0d results over %0d interval settings.",
                 model.commands, model.results, settings_used);
        $display("Parked %0d, value changed %0d, woken %0d, no waiter %0d,",
                 model.status_seen[0], model.status_seen[1], model.status_seen[2],
                 model.status_seen[3]);
        $display("cancelled %0d, not queued %0d, refused %0d.",
                 model.status_seen[4], model.status_seen[5], model.status_seen[6]);
        if (model.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run, full unpark-all scans and stalls included
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
